/* hdl/keyframe_track_sampler_top_assert.svh */
// Assertion macros shared by the keyframe track sampler RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef KEYFRAME_TRACK_SAMPLER_TOP_ASSERT_SVH
`define KEYFRAME_TRACK_SAMPLER_TOP_ASSERT_SVH
// same-cycle implication, disabled during reset
`define KTS_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/kts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the keyframe track sampler.
// No dependencies; imported by every module of the block.
package kts_pkg;

    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 33;
    localparam int ROOT_W     = 32;
    localparam int RADICAND_W = 64;

    localparam logic [16:0] FRAC_ONE = 17'h1_0000;
    localparam logic [31:0] Q_ONE    = 32'h0001_0000;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    localparam logic CFG_KEY_COUNT  = 1'b0;
    localparam logic CFG_TRACK_KIND = 1'b1;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
    } key_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_LAST,
        RD_MID,
        RD_LO,
        RD_UP
    } rd_sel_t;

    typedef enum logic {
        DIV_FRAC,
        DIV_NORM
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_CHK0,
        S_CHKL,
        S_SEARCH,
        S_SCMP,
        S_LO,
        S_UP,
        S_FDIV,
        S_LMUL,
        S_LADD,
        S_LDONE,
        S_SQMUL,
        S_SQACC,
        S_SQRT_GO,
        S_SQRT,
        S_NDIV_GO,
        S_NDIV_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     mem_wr;
        logic     q_load;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     res_zero;
        logic     res_from_rd;
        logic     res_from_c;
        logic     srch_init;
        logic     srch_step;
        logic     a_load;
        logic     b_load;
        logic     div_start;
        div_sel_t div_sel;
        logic     f_zero;
        logic     f_from_div;
        logic     k_clr;
        logic     k_inc;
        logic     lmul;
        logic     ladd;
        logic     sq_clr;
        logic     sqmul;
        logic     sqacc;
        logic     sqrt_start;
        logic     ndiv_store;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic rd_ge_q;
        logic rd_le_q;
        logic count_zero;
        logic rd_le_tp;
        logic q_le_tp;
        logic k_last;
        logic div_busy;
        logic div_done;
        logic sqrt_busy;
        logic sqrt_done;
        logic quat;
        logic out_free;
    } sts_t;

endpackage

/* hdl/kts_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on kts_pkg for operand widths.
module kts_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [kts_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [kts_pkg::DIVISOR_W-1:0]   divisor,
    output logic                            busy,
    output logic                            done,
    output logic [kts_pkg::DIVIDEND_W-1:0]  quotient
);
    import kts_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  ge;
    logic [DIVISOR_W:0]    rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* hdl/kts_isqrt.sv */
`timescale 1ns / 1ps
// Integer square root, two radicand bits per cycle (restoring form).
// Depends on kts_pkg for operand widths.
module kts_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [kts_pkg::RADICAND_W-1:0]  radicand,
    output logic                            busy,
    output logic                            done,
    output logic [kts_pkg::ROOT_W-1:0]      root
);
    import kts_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic [RADICAND_W-1:0] rad_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [ROOT_W+3:0]     rem_sh;
    logic [ROOT_W+3:0]     trial;
    logic                  ge;
    logic [ROOT_W+3:0]     rem_sub;

    assign rem_sh  = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RADICAND_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hdl/kts_datapath.sv */
`timescale 1ns / 1ps
// Datapath: key memory, search registers, lerp, norm and output register.
// Depends on kts_pkg, kts_div and kts_isqrt.
module kts_datapath #(
    parameter int MAX_KEYS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  kts_pkg::cmd_t   cmd,
    output kts_pkg::sts_t   sts,
    input  kts_pkg::key_t   in_key,
    input  logic [5:0]      in_index,
    input  logic [31:0]     in_qtime,
    input  logic [6:0]      key_count,
    input  logic            quat,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [127:0]    out_data
);
    import kts_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam logic [1:0] K_LAST = 2'd3;

    function automatic logic [31:0] comp_of(key_t k, logic [1:0] i);
        logic [31:0] v;
        case (i)
            2'd0:    v = k.x;
            2'd1:    v = k.y;
            2'd2:    v = k.z;
            default: v = k.w;
        endcase
        return v;
    endfunction

    key_t key_mem [MAX_KEYS];
    key_t rd_reg;
    key_t a_reg;
    key_t b_reg;

    logic [NW-1:0] n;
    logic [NW-1:0] first_reg;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] step;
    logic [NW-1:0] mid;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;

    logic [31:0]   q_reg;
    logic [16:0]   f_reg;
    logic [1:0]    k_reg;

    logic [31:0]          a_k;
    logic [31:0]          b_k;
    logic [31:0]          c_k;
    logic signed [32:0]   diff;
    logic signed [50:0]   prod;
    logic signed [50:0]   prod_reg;
    logic signed [50:0]   lerp_sum;
    logic [31:0]          c_reg [4];
    logic [31:0]          mag;
    logic [63:0]          sq_reg;
    logic [64:0]          acc_reg;
    logic [DIVISOR_W-1:0] norm;
    logic [31:0]          r_abs;

    logic [31:0] res_reg [4];
    logic        out_valid_reg;
    logic [127:0] out_data_reg;

    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    logic                  sqrt_busy;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;

    // effective key count, clamped to the table depth
    always_comb
    begin
        if (32'(key_count) > 32'(MAX_KEYS))
            n = NW'(MAX_KEYS);
        else
            n = NW'(key_count);
    end

    assign step    = count_reg >> 1;
    assign mid     = first_reg + step;
    assign wr_ok   = 32'(in_index) < 32'(MAX_KEYS);
    assign wr_addr = AW'(in_index);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_LAST: rd_addr = AW'(n - 1'b1);
            RD_MID:  rd_addr = AW'(mid);
            RD_LO:   rd_addr = AW'(first_reg - 1'b1);
            RD_UP:   rd_addr = AW'(first_reg);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_ok)
            key_mem[wr_addr] <= in_key;
        if (cmd.rd_en)
            rd_reg <= key_mem[rd_addr];
    end

    // per-component arithmetic
    assign a_k      = comp_of(a_reg, k_reg);
    assign b_k      = comp_of(b_reg, k_reg);
    assign c_k      = c_reg[k_reg];
    assign diff     = $signed({b_k[31], b_k}) - $signed({a_k[31], a_k});
    assign prod     = diff * $signed({1'b0, f_reg});
    assign lerp_sum = $signed({{19{a_k[31]}}, a_k}) + (prod_reg >>> 16);
    assign mag      = c_k[31] ? (~c_k + 32'd1) : c_k;
    assign norm     = acc_reg[64] ? {1'b1, 32'd0} : {1'b0, sqrt_root};
    assign r_abs    = div_quot[31:0];

    always_comb
    begin
        if (cmd.div_sel == DIV_FRAC)
        begin
            div_dividend = {q_reg - a_reg.t, 16'd0};
            div_divisor  = {1'b0, rd_reg.t - a_reg.t};
        end
        else
        begin
            div_dividend = {mag, 16'd0};
            div_divisor  = norm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= '0;
        else if (cmd.k_clr)
            k_reg <= '0;
        else if (cmd.k_inc)
            k_reg <= k_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
            q_reg <= in_qtime;
        if (cmd.srch_init)
        begin
            first_reg <= NW'(1);
            count_reg <= n - 1'b1;
        end
        else if (cmd.srch_step)
        begin
            if (rd_reg.t < q_reg)
            begin
                first_reg <= mid + 1'b1;
                count_reg <= count_reg - step - 1'b1;
            end
            else
                count_reg <= step;
        end
        if (cmd.a_load)
            a_reg <= rd_reg;
        if (cmd.b_load)
            b_reg <= rd_reg;
        if (cmd.f_zero)
            f_reg <= '0;
        else if (cmd.f_from_div)
            f_reg <= (div_quot > DIVIDEND_W'(FRAC_ONE)) ? FRAC_ONE : div_quot[16:0];
        if (cmd.lmul)
            prod_reg <= prod;
        if (cmd.ladd)
            c_reg[k_reg] <= lerp_sum[31:0];
        if (cmd.sqmul)
            sq_reg <= mag * mag;
        if (cmd.sq_clr)
            acc_reg <= '0;
        else if (cmd.sqacc)
            acc_reg <= acc_reg + {1'b0, sq_reg};
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_zero)
        begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
            res_reg[3] <= quat ? Q_ONE : 32'd0;
        end
        else if (cmd.res_from_rd)
        begin
            res_reg[0] <= rd_reg.x;
            res_reg[1] <= rd_reg.y;
            res_reg[2] <= rd_reg.z;
            res_reg[3] <= quat ? rd_reg.w : 32'd0;
        end
        else if (cmd.res_from_c)
        begin
            res_reg[0] <= c_reg[0];
            res_reg[1] <= c_reg[1];
            res_reg[2] <= c_reg[2];
            res_reg[3] <= '0;
        end
        else if (cmd.ndiv_store)
        begin
            if (norm == '0)
                res_reg[k_reg] <= '0;
            else if (c_k[31])
                res_reg[k_reg] <= ~r_abs + 32'd1;
            else
                res_reg[k_reg] <= r_abs;
        end
        if (cmd.out_load)
            out_data_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    kts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    kts_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg[63:0]),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        sts.n_zero     = n == '0;
        sts.n_one      = n == NW'(1);
        sts.rd_ge_q    = rd_reg.t >= q_reg;
        sts.rd_le_q    = rd_reg.t <= q_reg;
        sts.count_zero = count_reg == '0;
        sts.rd_le_tp   = rd_reg.t <= a_reg.t;
        sts.q_le_tp    = q_reg <= a_reg.t;
        sts.k_last     = k_reg == K_LAST;
        sts.div_busy   = div_busy;
        sts.div_done   = div_done;
        sts.sqrt_busy  = sqrt_busy;
        sts.sqrt_done  = sqrt_done;
        sts.quat       = quat;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/kts_ctrl.sv */
`timescale 1ns / 1ps
// Controller FSM: sequences write, search, lerp and renormalize steps.
// Depends on kts_pkg and the assertion macro header.
`include "keyframe_track_sampler_top_assert.svh"
module kts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_action,
    output logic            in_ready,
    input  kts_pkg::sts_t   sts,
    output kts_pkg::cmd_t   cmd
);
    import kts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_action == ACTION_QUERY)
                    state_next = S_START;
            S_START:
                state_next = sts.n_zero ? S_EMIT : S_CHK0;
            S_CHK0:
                state_next = (sts.n_one || sts.rd_ge_q) ? S_EMIT : S_CHKL;
            S_CHKL:
                state_next = sts.rd_le_q ? S_EMIT : S_SEARCH;
            S_SEARCH:
                state_next = sts.count_zero ? S_LO : S_SCMP;
            S_SCMP:
                state_next = S_SEARCH;
            S_LO:
                state_next = S_UP;
            S_UP:
                if (sts.rd_le_tp)
                    state_next = S_EMIT;
                else if (sts.q_le_tp)
                    state_next = S_LMUL;
                else
                    state_next = S_FDIV;
            S_FDIV:
                if (sts.div_done)
                    state_next = S_LMUL;
            S_LMUL:
                state_next = S_LADD;
            S_LADD:
                state_next = sts.k_last ? S_LDONE : S_LMUL;
            S_LDONE:
                state_next = sts.quat ? S_SQMUL : S_EMIT;
            S_SQMUL:
                state_next = S_SQACC;
            S_SQACC:
                state_next = sts.k_last ? S_SQRT_GO : S_SQMUL;
            S_SQRT_GO:
                state_next = S_SQRT;
            S_SQRT:
                if (sts.sqrt_done)
                    state_next = S_NDIV_GO;
            S_NDIV_GO:
                state_next = S_NDIV_WAIT;
            S_NDIV_WAIT:
                if (sts.div_done)
                    state_next = sts.k_last ? S_EMIT : S_NDIV_GO;
            S_EMIT:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.mem_wr = in_action == ACTION_WRITE;
                    cmd.q_load = in_action == ACTION_QUERY;
                end
            end
            S_START:
                if (sts.n_zero)
                    cmd.res_zero = 1'b1;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                end
            S_CHK0:
                if (sts.n_one || sts.rd_ge_q)
                    cmd.res_from_rd = 1'b1;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                end
            S_CHKL:
                if (sts.rd_le_q)
                    cmd.res_from_rd = 1'b1;
                else
                    cmd.srch_init = 1'b1;
            S_SEARCH:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sts.count_zero ? RD_LO : RD_MID;
            end
            S_SCMP:
                cmd.srch_step = 1'b1;
            S_LO:
            begin
                cmd.a_load = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_UP;
            end
            S_UP:
            begin
                cmd.b_load = 1'b1;
                cmd.k_clr  = 1'b1;
                if (sts.rd_le_tp)
                    cmd.res_from_rd = 1'b1;
                else if (sts.q_le_tp)
                    cmd.f_zero = 1'b1;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_FRAC;
                end
            end
            S_FDIV:
                cmd.f_from_div = sts.div_done;
            S_LMUL:
                cmd.lmul = 1'b1;
            S_LADD:
            begin
                cmd.ladd  = 1'b1;
                cmd.k_inc = !sts.k_last;
            end
            S_LDONE:
                if (sts.quat)
                begin
                    cmd.sq_clr = 1'b1;
                    cmd.k_clr  = 1'b1;
                end
                else
                    cmd.res_from_c = 1'b1;
            S_SQMUL:
                cmd.sqmul = 1'b1;
            S_SQACC:
            begin
                cmd.sqacc = 1'b1;
                cmd.k_inc = !sts.k_last;
            end
            S_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                cmd.k_clr      = 1'b1;
            end
            S_SQRT:
                cmd.div_sel = DIV_NORM;
            S_NDIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NORM;
            end
            S_NDIV_WAIT:
            begin
                cmd.div_sel = DIV_NORM;
                if (sts.div_done)
                begin
                    cmd.ndiv_store = 1'b1;
                    cmd.k_inc      = !sts.k_last;
                end
            end
            S_EMIT:
                cmd.out_load = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

    `KTS_ASSERT_NOW(a_div_free, cmd.div_start, !sts.div_busy, "divider started while busy")
    `KTS_ASSERT_NOW(a_sqrt_free, cmd.sqrt_start, !sts.sqrt_busy, "sqrt started while busy")
    `KTS_ASSERT_NOW(a_out_free, cmd.out_load, sts.out_free, "result loaded over a waiting beat")
    `KTS_ASSERT_NEXT(a_div_wait, cmd.div_start, state_reg == S_FDIV || state_reg == S_NDIV_WAIT, "no wait state after divider start")

endmodule

/* hdl/keyframe_track_sampler_top.sv */
`timescale 1ns / 1ps
// Keyframe track sampler, top level. A key write beat is stored as it is accepted.
// Queries return an end key at the table ends; else a binary search (about log2(n)
// steps, single memory port) finds the span: its upper key is returned if it is
// non-positive, else keys are interpolated, quaternions with a sqrt and four divides.
// One query at a time; a result beat waiting on m_tready holds the block. rst_n is
// asynchronous, active low: clears FSM, output valid and config; key memory is not reset.
module keyframe_track_sampler_top #(
    parameter int MAX_KEYS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // input beat channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, lowest bit up: key_index[5:0], key_time[37:6], key_x[69:38],
    // key_y[101:70], key_z[133:102], key_w[165:134], query_time[197:166], zero pad
    input  logic [199:0] s_tdata,
    // s_tuser: action (0 write key, 1 query)
    input  logic         s_tuser,
    // result beat channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, lowest bit up: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] m_tdata,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_wdata
);
    import kts_pkg::*;

    logic [6:0] key_count_reg;
    logic       track_kind_reg;
    key_t       in_key;
    cmd_t       cmd;
    sts_t       sts;

    // config registers must be written only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg  <= '0;
            track_kind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_COUNT:  key_count_reg  <= cfg_wdata;
                CFG_TRACK_KIND: track_kind_reg <= cfg_wdata[0];
                default:        key_count_reg  <= key_count_reg;
            endcase
        end
    end

    // unpack the key fields of an input beat
    assign in_key.t = s_tdata[37:6];
    assign in_key.x = s_tdata[69:38];
    assign in_key.y = s_tdata[101:70];
    assign in_key.z = s_tdata[133:102];
    assign in_key.w = s_tdata[165:134];

    kts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kts_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_key    (in_key),
        .in_index  (s_tdata[5:0]),
        .in_qtime  (s_tdata[197:166]),
        .key_count (key_count_reg),
        .quat      (track_kind_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule
